/* hw/rtl/utu_pkg.sv */
`timescale 1ns / 1ps

package utu_pkg;

	localparam logic [15:0] UNIT_REPL   = 16'hFFFD;
	localparam logic [15:0] HI_SURR     = 16'hD800;
	localparam logic [15:0] LO_SURR     = 16'hDC00;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;
	localparam logic [20:0] CP_MAX      = 21'h10FFFF;
	localparam logic [20:0] MIN_2BYTE   = 21'h80;
	localparam logic [20:0] MAX_2BYTE   = 21'h7FF;
	localparam logic [20:0] MIN_3BYTE   = 21'h800;
	localparam logic [20:0] MAX_BMP     = 21'hFFFF;
	localparam logic [20:0] SURR_LO_END = 21'hD7FF;
	localparam logic [20:0] SURR_HI_END = 21'hE000;

	typedef struct packed {
		logic        aborted;
		logic [20:0] acc;
		logic [1:0]  conts;
		logic [1:0]  seq_len;
	} dec_state_t;

	typedef struct packed {
		logic [1:0]  n;
		logic [15:0] u0;
		logic [15:0] u1;
		logic        fail;
		logic        last0;
		logic        last1;
	} dec_result_t;

endpackage

/* hw/rtl/utu_decode.sv */
`timescale 1ns / 1ps

module utu_decode (
	input  utu_pkg::dec_state_t  st,
	input  logic [7:0]           data_byte,
	input  logic                 end_of_string,
	output utu_pkg::dec_state_t  nxt,
	output utu_pkg::dec_result_t res
);

	logic        is_cont;
	logic        lead_ascii;
	logic        lead_bad;
	logic [1:0]  lead_len;
	logic [20:0] lead_acc;
	logic [20:0] acc2;
	logic [1:0]  conts2;
	logic [20:0] off;
	logic        fin_ok;

	assign is_cont    = (data_byte[7:6] == 2'b10);
	assign lead_ascii = ~data_byte[7];
	assign lead_bad   = is_cont | (data_byte[7:3] == 5'b11111);
	assign acc2       = {st.acc[14:0], data_byte[5:0]};
	assign conts2     = st.conts + 2'd1;
	assign off        = acc2 - utu_pkg::SUPP_BASE;

	always_comb begin
		if (data_byte[7:5] == 3'b110) begin
			lead_len = 2'd1;
			lead_acc = {16'd0, data_byte[4:0]};
		end else if (data_byte[7:4] == 4'b1110) begin
			lead_len = 2'd2;
			lead_acc = {17'd0, data_byte[3:0]};
		end else begin
			lead_len = 2'd3;
			lead_acc = {18'd0, data_byte[2:0]};
		end
	end

	always_comb begin
		case (st.seq_len)
			2'd1:    fin_ok = (acc2 >= utu_pkg::MIN_2BYTE) && (acc2 <= utu_pkg::MAX_2BYTE);
			2'd2:    fin_ok = (acc2 >= utu_pkg::MIN_3BYTE) && (acc2 <= utu_pkg::MAX_BMP) &&
			                  !((acc2 > utu_pkg::SURR_LO_END) && (acc2 < utu_pkg::SURR_HI_END));
			default: fin_ok = (acc2 > utu_pkg::MAX_BMP) && (acc2 <= utu_pkg::CP_MAX);
		endcase
	end

	always_comb begin
		logic       ok;
		logic       do_lead;
		logic [1:0] nu;
		ok      = 1'b1;
		do_lead = 1'b0;
		nu      = 2'd0;
		nxt     = st;
		res     = '0;

		if (st.aborted) begin
			ok = 1'b1;
		end else if (st.seq_len != 2'd0) begin
			if (is_cont) begin
				nxt.acc   = acc2;
				nxt.conts = conts2;
				if (conts2 == st.seq_len) begin
					nxt.seq_len = 2'd0;
					nxt.conts   = 2'd0;
					nxt.acc     = '0;
					if (!fin_ok) begin
						ok = 1'b0;
					end else if (st.seq_len == 2'd3) begin
						res.u0 = utu_pkg::HI_SURR + {6'd0, off[19:10]};
						res.u1 = utu_pkg::LO_SURR + {6'd0, off[9:0]};
						nu     = 2'd2;
					end else begin
						res.u0 = acc2[15:0];
						nu     = 2'd1;
					end
				end else if (end_of_string) begin
					ok = 1'b0;
				end
			end else if (st.conts != 2'd0) begin
				ok = 1'b0;
			end else begin
				res.u0      = utu_pkg::UNIT_REPL;
				nu          = 2'd1;
				nxt.seq_len = 2'd0;
				nxt.acc     = '0;
				do_lead     = 1'b1;
			end
		end else begin
			do_lead = 1'b1;
		end

		if (do_lead) begin
			if (lead_ascii) begin
				if (nu == 2'd0) res.u0 = {8'd0, data_byte};
				else            res.u1 = {8'd0, data_byte};
				nu = nu + 2'd1;
			end else if (lead_bad) begin
				ok = 1'b0;
			end else if (end_of_string) begin
				if (nu == 2'd0) res.u0 = utu_pkg::UNIT_REPL;
				else            res.u1 = utu_pkg::UNIT_REPL;
				nu = nu + 2'd1;
			end else begin
				nxt.seq_len = lead_len;
				nxt.acc     = lead_acc;
				nxt.conts   = 2'd0;
			end
		end

		if (!ok) begin
			nxt.aborted = 1'b1;
			nxt.seq_len = 2'd0;
			nxt.conts   = 2'd0;
			nxt.acc     = '0;
			nu          = 2'd0;
		end

		if (end_of_string && nxt.aborted) begin
			res.u0    = '0;
			res.u1    = '0;
			res.fail  = 1'b1;
			res.last0 = 1'b1;
			nu        = 2'd1;
			nxt       = '0;
		end else if (nxt.aborted) begin
			nu = 2'd0;
		end else if (end_of_string) begin
			res.last0 = (nu == 2'd1);
			res.last1 = (nu == 2'd2);
			nxt       = '0;
		end
		res.n = nu;
	end

endmodule

/* hw/rtl/utf8_to_utf16_transcoder_core.sv */
`timescale 1ns / 1ps
// A byte's first UTF-16 unit is registered and appears on the output in the cycle after its input beat is accepted.
// Throughput: one byte per cycle while the output is ready; a byte that yields a surrogate pair holds the
// input while the two-entry result buffer drains.
// Bytes that yield nothing (lead and inner continuation bytes) leave the result buffer empty.
// Reset (arst_n low, async): decoder state cleared, result buffer emptied.

module utf8_to_utf16_transcoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // end_of_string
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] unit
	output logic        m_axis_tuser,   // failed
	output logic        m_axis_tlast    // last_unit
);

	utu_pkg::dec_state_t  st_q;
	utu_pkg::dec_state_t  st_nxt;
	utu_pkg::dec_result_t res;

	logic [1:0]  cnt_q;
	logic [15:0] u0_q;
	logic [15:0] u1_q;
	logic        fail_q;
	logic        last0_q;
	logic        last1_q;
	logic        pop;
	logic        load;

	utu_decode u_decode (
		.st            (st_q),
		.data_byte     (s_axis_tdata),
		.end_of_string (s_axis_tlast),
		.nxt           (st_nxt),
		.res           (res)
	);

	assign pop           = m_axis_tvalid & m_axis_tready;
	assign s_axis_tready = (cnt_q == 2'd0) | ((cnt_q == 2'd1) & m_axis_tready);
	assign load          = s_axis_tvalid & s_axis_tready;

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = u0_q;
	assign m_axis_tuser  = fail_q;
	assign m_axis_tlast  = last0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			cnt_q <= 2'd0;
		end else if (load) begin
			st_q  <= st_nxt;
			cnt_q <= res.n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// result buffer payload
	always_ff @(posedge clk) begin
		if (load) begin
			u0_q    <= res.u0;
			u1_q    <= res.u1;
			fail_q  <= res.fail;
			last0_q <= res.last0;
			last1_q <= res.last1;
		end else if (pop && cnt_q == 2'd2) begin
			u0_q    <= u1_q;
			fail_q  <= 1'b0;
			last0_q <= last1_q;
		end
	end

endmodule

/* hw/rtl/utu_checker.sv */
`timescale 1ns / 1ps

module utu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);

	logic hi_surr;
	logic lo_surr;

	assign hi_surr = (m_axis_tdata[15:10] == 6'b110110);
	assign lo_surr = (m_axis_tdata[15:10] == 6'b110111);

	// error beat is a lone zero closing the string
	a_fail_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 16'd0)
		else $error("error beat malformed");

	// a high surrogate never closes a string
	a_hi_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser && hi_surr |-> !m_axis_tlast)
		else $error("high surrogate marked last");

	// low surrogate follows a high one right away
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tuser && hi_surr |=>
		m_axis_tvalid && lo_surr && !m_axis_tuser)
		else $error("surrogate pair broken");

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("output beat changed under stall");

endmodule

bind utf8_to_utf16_transcoder_core utu_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
